>>> rtl/msgr_pkg.sv
// Shared types and constants for the message ring FIFO.
`timescale 1ns / 1ps

package msgr_pkg;

   localparam int LEN_W = 7;
   localparam int CAP_W = 7;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_BADARG = 3'd2,
      ST_FULL   = 3'd3,
      ST_SMALL  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REJ_NONE = 2'd0,
      REJ_FULL = 2'd1,
      REJ_LONG = 2'd2
   } reject_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_POP_LEN,
      FSM_POP_STREAM
   } fsm_type;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data_byte;
      logic             end_of_message;
      logic [CAP_W-1:0] capacity;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic             from_pop;
      logic [7:0]       data_byte_res;
      logic [LEN_W-1:0] length;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic byte_we;
      logic len_we;
   } mem_ctl_type;

endpackage

>>> rtl/msgr_store.sv
// Byte memory and length memory of the ring, registered synchronous read.
`timescale 1ns / 1ps

module msgr_store #(
   parameter int HW   = 4,
   parameter int CW   = 6,
   parameter int CURW = 7,
   parameter int RING_DEPTH = 16
) (
   input  logic                  clock,
   input  msgr_pkg::mem_ctl_type mem_ctl,
   input  logic [HW+CW-1:0]      byte_wr_addr,
   input  logic [7:0]            byte_wr_data,
   input  logic [HW+CW-1:0]      byte_rd_addr,
   output logic [7:0]            byte_rd_data,
   input  logic [HW-1:0]         len_wr_addr,
   input  logic [CURW-1:0]       len_wr_data,
   input  logic [HW-1:0]         len_rd_addr,
   output logic [CURW-1:0]       len_rd_data
);

   localparam int BYTE_DEPTH = RING_DEPTH * (2 ** CW);

   logic [7:0]      byte_mem [BYTE_DEPTH];
   logic [CURW-1:0] len_mem  [RING_DEPTH];
   logic [7:0]      byte_q_ff;
   logic [CURW-1:0] len_q_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.byte_we) begin
         byte_mem[byte_wr_addr] <= byte_wr_data;
      end
      byte_q_ff <= byte_mem[byte_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.len_we) begin
         len_mem[len_wr_addr] <= len_wr_data;
      end
      len_q_ff <= len_mem[len_rd_addr];
   end

   assign byte_rd_data = byte_q_ff;
   assign len_rd_data  = len_q_ff;

endmodule

>>> rtl/msgr_ctrl.sv
// Ring pointers, push bookkeeping and pop sequencer.
`timescale 1ns / 1ps

module msgr_ctrl #(
   parameter int HW   = 4,
   parameter int CW   = 6,
   parameter int CURW = 7,
   parameter int CNTW = 5,
   parameter int RING_DEPTH = 16,
   parameter int MSG_BYTES  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  msgr_pkg::req_type     req_data,
   output logic                  busy,
   output logic                  res_valid,
   output msgr_pkg::rsp_type     res,
   output msgr_pkg::mem_ctl_type mem_ctl,
   output logic [HW+CW-1:0]      byte_wr_addr,
   output logic [7:0]            byte_wr_data,
   output logic [HW+CW-1:0]      byte_rd_addr,
   input  logic [7:0]            byte_rd_data,
   output logic [HW-1:0]         len_wr_addr,
   output logic [CURW-1:0]       len_wr_data,
   output logic [HW-1:0]         len_rd_addr,
   input  logic [CURW-1:0]       len_rd_data
);

   localparam logic [msgr_pkg::CAP_W-1:0] CAP_MAX = msgr_pkg::CAP_W'(MSG_BYTES + 1);
   localparam logic [HW-1:0]   HEAD_LAST = HW'(RING_DEPTH - 1);
   localparam logic [CNTW-1:0] CNT_FULL  = CNTW'(RING_DEPTH);
   localparam logic [CURW-1:0] CUR_MAX   = CURW'(MSG_BYTES);

   msgr_pkg::fsm_type    state_ff, state_in;
   msgr_pkg::reject_type rej_ff, rej_in;
   logic [HW-1:0]   head_ff, head_in;
   logic [HW-1:0]   tail_ff, tail_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CURW-1:0] cursor_ff, cursor_in;
   logic [CURW-1:0] emit_ff, emit_in;
   logic [msgr_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [CURW-1:0] emit_next;
   logic [CURW-1:0] cur_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= msgr_pkg::FSM_IDLE;
         rej_ff    <= msgr_pkg::REJ_NONE;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         cursor_ff <= '0;
         emit_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rej_ff    <= rej_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         emit_ff   <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
   end

   assign emit_next    = emit_ff + 1'b1;
   assign cur_next     = cursor_ff + 1'b1;
   assign busy         = (state_ff != msgr_pkg::FSM_IDLE);
   assign byte_wr_addr = {tail_ff, cursor_ff[CW-1:0]};
   assign byte_wr_data = req_data.data_byte;
   assign byte_rd_addr = busy ? {head_ff, emit_next[CW-1:0]} : {head_ff, CW'(0)};
   assign len_wr_addr  = tail_ff;
   assign len_rd_addr  = head_ff;

   always_comb begin
      msgr_pkg::reject_type rej_v;
      logic [CURW-1:0]      cur_v;
      state_in    = state_ff;
      rej_in      = rej_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      emit_in     = emit_ff;
      cap_in      = cap_ff;
      res_valid   = 1'b0;
      res         = '0;
      mem_ctl     = '0;
      len_wr_data = cur_next;
      rej_v       = rej_ff;
      cur_v       = cursor_ff;
      case (state_ff)
         msgr_pkg::FSM_IDLE: begin
            if (start && req_data.kind == msgr_pkg::KIND_PUSH) begin
               if (cursor_ff == '0 && rej_v == msgr_pkg::REJ_NONE && count_ff >= CNT_FULL) begin
                  rej_v = msgr_pkg::REJ_FULL;
               end
               if (cursor_ff < CUR_MAX) begin
                  mem_ctl.byte_we = (rej_v == msgr_pkg::REJ_NONE);
                  cur_v = cur_next;
               end else begin
                  rej_v = msgr_pkg::REJ_LONG;
               end
               if (req_data.end_of_message) begin
                  res_valid = 1'b1;
                  res.last  = 1'b1;
                  case (rej_v)
                     msgr_pkg::REJ_LONG: res.status = msgr_pkg::ST_BADARG;
                     msgr_pkg::REJ_FULL: res.status = msgr_pkg::ST_FULL;
                     default: begin
                        res.status     = msgr_pkg::ST_OK;
                        mem_ctl.len_we = 1'b1;
                        tail_in  = (tail_ff == HEAD_LAST) ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  endcase
                  cursor_in = '0;
                  rej_in    = msgr_pkg::REJ_NONE;
               end else begin
                  cursor_in = cur_v;
                  rej_in    = rej_v;
               end
            end else if (start) begin
               if (req_data.capacity == '0 || req_data.capacity > CAP_MAX) begin
                  res_valid    = 1'b1;
                  res.status   = msgr_pkg::ST_BADARG;
                  res.from_pop = 1'b1;
                  res.last     = 1'b1;
               end else if (count_ff == '0) begin
                  res_valid    = 1'b1;
                  res.status   = msgr_pkg::ST_EMPTY;
                  res.from_pop = 1'b1;
                  res.last     = 1'b1;
               end else begin
                  cap_in   = req_data.capacity;
                  emit_in  = '0;
                  state_in = msgr_pkg::FSM_POP_LEN;
               end
            end
         end
         msgr_pkg::FSM_POP_LEN, msgr_pkg::FSM_POP_STREAM: begin
            res_valid    = 1'b1;
            res.from_pop = 1'b1;
            if (state_ff == msgr_pkg::FSM_POP_LEN
                && cap_ff <= msgr_pkg::LEN_W'(len_rd_data)) begin
               res.status = msgr_pkg::ST_SMALL;
               res.last   = 1'b1;
               state_in   = msgr_pkg::FSM_IDLE;
            end else begin
               res.status        = msgr_pkg::ST_OK;
               res.data_byte_res = byte_rd_data;
               res.length        = msgr_pkg::LEN_W'(len_rd_data);
               res.last          = (emit_next == len_rd_data);
               emit_in           = emit_next;
               if (emit_next == len_rd_data) begin
                  head_in  = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
                  state_in = msgr_pkg::FSM_IDLE;
               end else begin
                  state_in = msgr_pkg::FSM_POP_STREAM;
               end
            end
         end
         default: begin
            state_in = msgr_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/message_ring_fifo.sv
// Message ring FIFO top level: pointer control, ring memories and result register.
// Push: one byte a cycle when idle, never busy; final byte answers in the next cycle.
// Pop: bad-argument and empty answer in the next cycle, busy stays low.
// Pop ok: bytes follow through the memory read and result registers, one a cycle
// over the byte read port; busy while streaming (for the length check if too small).
// Reset clears pointers, count, cursor and sequencer; memories are left as they are.
`timescale 1ns / 1ps

module message_ring_fifo #(
   parameter int RING_DEPTH = 16,
   parameter int MSG_BYTES  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  msgr_pkg::req_type req_data,
   output logic              rsp_valid,
   output msgr_pkg::rsp_type rsp_data
);

   localparam int HW   = $clog2(RING_DEPTH);
   localparam int CW   = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
   localparam int CURW = $clog2(MSG_BYTES + 1);
   localparam int CNTW = $clog2(RING_DEPTH + 1);

   msgr_pkg::mem_ctl_type mem_ctl;
   msgr_pkg::rsp_type     res;
   logic                  res_valid;
   logic [HW+CW-1:0]      byte_wr_addr;
   logic [7:0]            byte_wr_data;
   logic [HW+CW-1:0]      byte_rd_addr;
   logic [7:0]            byte_rd_data;
   logic [HW-1:0]         len_wr_addr;
   logic [CURW-1:0]       len_wr_data;
   logic [HW-1:0]         len_rd_addr;
   logic [CURW-1:0]       len_rd_data;
   logic                  rsp_valid_ff;
   msgr_pkg::rsp_type     rsp_data_ff;

   msgr_ctrl #(
      .HW(HW), .CW(CW), .CURW(CURW), .CNTW(CNTW),
      .RING_DEPTH(RING_DEPTH), .MSG_BYTES(MSG_BYTES)
   ) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .res_valid(res_valid), .res(res), .mem_ctl(mem_ctl),
      .byte_wr_addr(byte_wr_addr), .byte_wr_data(byte_wr_data),
      .byte_rd_addr(byte_rd_addr), .byte_rd_data(byte_rd_data),
      .len_wr_addr(len_wr_addr), .len_wr_data(len_wr_data),
      .len_rd_addr(len_rd_addr), .len_rd_data(len_rd_data)
   );

   msgr_store #(
      .HW(HW), .CW(CW), .CURW(CURW), .RING_DEPTH(RING_DEPTH)
   ) u_store (
      .clock(clock), .mem_ctl(mem_ctl),
      .byte_wr_addr(byte_wr_addr), .byte_wr_data(byte_wr_data),
      .byte_rd_addr(byte_rd_addr), .byte_rd_data(byte_rd_data),
      .len_wr_addr(len_wr_addr), .len_wr_data(len_wr_data),
      .len_rd_addr(len_rd_addr), .len_rd_data(len_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_push_keeps_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == msgr_pkg::KIND_PUSH) |=> !busy)
      else $error("push request left the block busy");

   a_zero_cap_badarg: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == msgr_pkg::KIND_POP && req_data.capacity == '0)
      |=> (rsp_valid && rsp_data.from_pop && rsp_data.status == msgr_pkg::ST_BADARG))
      else $error("zero capacity pop not rejected");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != msgr_pkg::ST_OK) |-> rsp_data.last)
      else $error("error status not marked last");

   a_push_no_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.from_pop) |-> (rsp_data.length == '0 && rsp_data.last))
      else $error("push answer carries a length");

endmodule

>>> dv/tb_message_ring_fifo.sv
// Self-checking testbench for the message ring FIFO: directed and random push/pop traffic.
`timescale 1ns / 1ps

module tb_message_ring_fifo;

   localparam int RING_DEPTH   = 16;
   localparam int MSG_BYTES    = 64;
   localparam int RANDOM_ITEMS = 85;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   msgr_pkg::req_type req_data;
   logic              rsp_valid;
   msgr_pkg::rsp_type rsp_data;

   message_ring_fifo #(
      .RING_DEPTH(RING_DEPTH),
      .MSG_BYTES (MSG_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   logic [7:0]                 ring_bytes [RING_DEPTH][MSG_BYTES];
   logic [msgr_pkg::LEN_W-1:0] ring_len [RING_DEPTH];
   int                         head_idx;
   int                         tail_idx;
   int                         entries;
   int                         cursor;
   msgr_pkg::reject_type       reject;

   msgr_pkg::rsp_type due_answers [$];
   int                faults;
   int                accepted_items;
   int                cycles;
   bit                no_idle;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("message_ring_fifo regression: fail");
         $finish;
      end
   end

   function automatic void report_fault(string msg);
      faults++;
      if (faults <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   function automatic void ring_answer(msgr_pkg::req_type r);
      msgr_pkg::rsp_type a;
      int                slot;
      int                len;
      a      = '0;
      a.last = 1'b1;
      if (r.kind == msgr_pkg::KIND_PUSH) begin
         slot = tail_idx;
         if (cursor == 0 && reject == msgr_pkg::REJ_NONE && entries >= RING_DEPTH)
            reject = msgr_pkg::REJ_FULL;
         if (cursor < MSG_BYTES) begin
            if (reject == msgr_pkg::REJ_NONE)
               ring_bytes[slot][cursor] = r.data_byte;
            cursor++;
         end else begin
            reject = msgr_pkg::REJ_LONG;
         end
         if (r.end_of_message) begin
            if (reject == msgr_pkg::REJ_LONG) begin
               a.status = msgr_pkg::ST_BADARG;
            end else if (reject == msgr_pkg::REJ_FULL) begin
               a.status = msgr_pkg::ST_FULL;
            end else begin
               ring_len[slot] = msgr_pkg::LEN_W'(cursor);
               tail_idx       = (slot + 1) % RING_DEPTH;
               entries++;
               a.status = msgr_pkg::ST_OK;
            end
            cursor = 0;
            reject = msgr_pkg::REJ_NONE;
            due_answers.push_back(a);
         end
      end else begin
         a.from_pop = 1'b1;
         if (r.capacity == 0 || r.capacity > MSG_BYTES + 1) begin
            a.status = msgr_pkg::ST_BADARG;
            due_answers.push_back(a);
         end else if (entries == 0) begin
            a.status = msgr_pkg::ST_EMPTY;
            due_answers.push_back(a);
         end else begin
            slot = head_idx;
            len  = ring_len[slot];
            if (r.capacity <= len) begin
               a.status = msgr_pkg::ST_SMALL;
               due_answers.push_back(a);
            end else begin
               for (int i = 0; i < len; i++) begin
                  a.status        = msgr_pkg::ST_OK;
                  a.data_byte_res = ring_bytes[slot][i];
                  a.length        = msgr_pkg::LEN_W'(len);
                  a.last          = (i + 1 == len);
                  due_answers.push_back(a);
               end
               head_idx = (slot + 1) % RING_DEPTH;
               entries--;
            end
         end
      end
   endfunction

   always @(posedge clock) begin : check_answers
      msgr_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_answers.size() == 0) begin
            report_fault($sformatf("unexpected answer: status=%0d pop=%0d byte=%02h len=%0d",
                                   rsp_data.status, rsp_data.from_pop,
                                   rsp_data.data_byte_res, rsp_data.length));
         end else begin
            want = due_answers.pop_front();
            if (rsp_data.status !== want.status || rsp_data.from_pop !== want.from_pop ||
                rsp_data.data_byte_res !== want.data_byte_res ||
                rsp_data.length !== want.length || rsp_data.last !== want.last)
               report_fault($sformatf({"answer mismatch: exp status=%0d pop=%0d byte=%02h ",
                                       "len=%0d last=%0d, got status=%0d pop=%0d byte=%02h ",
                                       "len=%0d last=%0d"},
                                      want.status, want.from_pop, want.data_byte_res,
                                      want.length, want.last, rsp_data.status,
                                      rsp_data.from_pop, rsp_data.data_byte_res,
                                      rsp_data.length, rsp_data.last));
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic msgr_pkg::req_type random_item();
      msgr_pkg::req_type r;
      r.kind           = 1'($urandom_range(0, 1));
      r.data_byte      = 8'($urandom_range(0, 255));
      r.end_of_message = 1'($urandom_range(0, 1));
      r.capacity       = msgr_pkg::CAP_W'($urandom_range(0, 127));
      return r;
   endfunction

   function automatic msgr_pkg::req_type push_item(logic [7:0] b, logic eom);
      msgr_pkg::req_type r;
      r                = random_item();
      r.kind           = msgr_pkg::KIND_PUSH;
      r.data_byte      = b;
      r.end_of_message = eom;
      return r;
   endfunction

   function automatic msgr_pkg::req_type pop_item(int cap);
      msgr_pkg::req_type r;
      r          = random_item();
      r.kind     = msgr_pkg::KIND_POP;
      r.capacity = msgr_pkg::CAP_W'(cap);
      return r;
   endfunction

   function automatic int pick_capacity();
      int r;
      int len;
      r   = $urandom_range(0, 99);
      len = (entries > 0) ? int'(ring_len[head_idx]) : 0;
      if (r < 55)
         return $urandom_range(len + 1, MSG_BYTES + 1);
      if (r < 70)
         return (len > 0) ? $urandom_range(1, len) : 1;
      if (r < 80)
         return $urandom_range(0, 1) ? 0 : $urandom_range(MSG_BYTES + 2, 127);
      return $urandom_range(0, 127);
   endfunction

   task automatic send_request(input msgr_pkg::req_type r, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      ring_answer(r);
      accepted_items++;
   endtask

   task automatic push_message(input int len, input int pop_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < pop_pct)
            send_request(pop_item(pick_capacity()), pick_gap());
         send_request(push_item(8'($urandom_range(0, 255)), i == len - 1), pick_gap());
      end
   endtask

   task automatic test_bad_and_empty_pops();
      send_request(pop_item(0), pick_gap());
      send_request(pop_item(MSG_BYTES + 2), pick_gap());
      send_request(pop_item(127), pick_gap());
      send_request(pop_item(1), pick_gap());
      send_request(pop_item(MSG_BYTES + 1), pick_gap());
   endtask

   task automatic test_short_message();
      send_request(push_item(8'h00, 1'b0), pick_gap());
      send_request(push_item(8'hFF, 1'b1), pick_gap());
      send_request(pop_item(2), pick_gap());
      send_request(pop_item(3), pick_gap());
   endtask

   task automatic test_length_limits();
      push_message(MSG_BYTES, 0);
      send_request(pop_item(MSG_BYTES), pick_gap());
      send_request(pop_item(MSG_BYTES + 1), pick_gap());
      push_message(MSG_BYTES + 1, 0);
   endtask

   task automatic test_full_ring();
      no_idle = 1'b1;
      for (int i = 0; i < RING_DEPTH; i++)
         push_message(1, 0);
      no_idle = 1'b0;
      // sample full on the first byte, then free a slot before the final byte
      send_request(push_item(8'($urandom_range(0, 255)), 1'b0), pick_gap());
      send_request(pop_item(MSG_BYTES + 1), pick_gap());
      send_request(push_item(8'($urandom_range(0, 255)), 1'b1), pick_gap());
      push_message(1, 0);
      push_message(MSG_BYTES + 2, 0);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int r;
      int push_pct;
      int len;
      stop_at = accepted_items + RANDOM_ITEMS;
      while (accepted_items < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            no_idle = !no_idle;
         push_pct = ((accepted_items / 50) % 2 == 0) ? 30 : 70;
         r        = $urandom_range(0, 99);
         if (r < 10) begin
            send_request(random_item(), pick_gap());
         end else if (r < 10 + push_pct * 9 / 10) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               len = $urandom_range(1, 4);
            else if (r < 90)
               len = $urandom_range(5, 16);
            else if (r < 96)
               len = $urandom_range(17, MSG_BYTES - 1);
            else if (r < 98)
               len = MSG_BYTES;
            else
               len = $urandom_range(MSG_BYTES + 1, MSG_BYTES + 3);
            push_message(len, 8);
         end else begin
            send_request(pop_item(pick_capacity()), pick_gap());
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic finish_run();
      start <= 1'b0;
      while (due_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0)
         $display("message_ring_fifo regression: pass");
      else
         $display("message_ring_fifo regression: fail");
      $finish;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      faults         = 0;
      accepted_items = 0;
      cycles         = 0;
      no_idle        = 1'b0;
      head_idx       = 0;
      tail_idx       = 0;
      entries        = 0;
      cursor         = 0;
      reject         = msgr_pkg::REJ_NONE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_bad_and_empty_pops();
      test_short_message();
      test_length_limits();
      test_full_ring();
      test_random_traffic();
      finish_run();
   end

endmodule

>>> files.f
rtl/msgr_pkg.sv
rtl/msgr_store.sv
rtl/msgr_ctrl.sv
rtl/message_ring_fifo.sv
dv/tb_message_ring_fifo.sv
